// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the encoder checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/xie_pkg.sv =====
package xie_pkg;

   // Longest instruction the encoder emits, in bytes.
   localparam int unsigned MaxBytes = 10;
   localparam int unsigned CountWidth = $clog2(MaxBytes + 1);
   localparam int unsigned AddrWidth = 32;

   // Default depth of the queue between the front and back parts.
   localparam int unsigned QueueDepthDefault = 2;

   // Request codes.
   localparam logic [4:0] REQ_MOVIMM  = 5'd0;
   localparam logic [4:0] REQ_MOVREG  = 5'd1;
   localparam logic [4:0] REQ_CALL    = 5'd2;
   localparam logic [4:0] REQ_CMP8MEM = 5'd3;
   localparam logic [4:0] REQ_CMP64   = 5'd4;
   localparam logic [4:0] REQ_LOAD64  = 5'd5;
   localparam logic [4:0] REQ_STORE8  = 5'd6;
   localparam logic [4:0] REQ_JMP     = 5'd7;
   localparam logic [4:0] REQ_JCC     = 5'd8;
   localparam logic [4:0] REQ_JMPREG  = 5'd9;
   localparam logic [4:0] REQ_JMPMEM  = 5'd10;
   localparam logic [4:0] REQ_ADDIMM  = 5'd11;
   localparam logic [4:0] REQ_ADD64   = 5'd12;
   localparam logic [4:0] REQ_RET     = 5'd13;
   localparam logic [4:0] REQ_INT3    = 5'd14;
   localparam logic [4:0] REQ_LABEL   = 5'd15;
   localparam logic [4:0] REQ_LINK    = 5'd16;

   // Opcode bytes.
   localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
   localparam logic [7:0] OP_MOV_RR   = 8'h89;
   localparam logic [7:0] OP_GRP1_IMM8 = 8'h80;
   localparam logic [7:0] OP_CMP_RR   = 8'h39;
   localparam logic [7:0] OP_MOV_LOAD = 8'h8B;
   localparam logic [7:0] OP_MOV_ST8  = 8'hC6;
   localparam logic [7:0] OP_JMP_REL  = 8'hE9;
   localparam logic [7:0] OP_ESCAPE   = 8'h0F;
   localparam logic [7:0] OP_GRP1_IMM32 = 8'h81;
   localparam logic [7:0] OP_ADD_RR   = 8'h03;
   localparam logic [7:0] OP_RET      = 8'hC3;
   localparam logic [7:0] OP_INT3     = 8'hCC;
   localparam logic [7:0] OP_GRP5     = 8'hFF;
   localparam logic [3:0] REX_HIGH    = 4'h4;
   localparam logic [3:0] JCC_HIGH    = 4'h8;
   localparam logic [1:0] MOD_REG     = 2'b11;
   localparam logic [1:0] MOD_DISP32  = 2'b10;
   localparam logic [1:0] MOD_NODISP  = 2'b00;
   localparam logic [2:0] RM_SIB      = 3'd4;

   // One encoded request as it travels from the front to the back part.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountWidth-1:0]    count;
      logic [AddrWidth-1:0]     addr;
      logic                     no_write;
      logic                     err;
   } entry_type;

endpackage

// ===== rtl/core/xie_front.sv =====
module xie_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [4:0]           req_type,
   input  logic [3:0]           req_reg_a,
   input  logic [3:0]           req_reg_b,
   input  logic [3:0]           req_mem_base,
   input  logic [3:0]           req_mem_index,
   input  logic [2:0]           req_mem_scale,
   input  logic signed [31:0]   req_mem_disp,
   input  logic [63:0]          req_imm,
   input  logic [3:0]           req_cond,
   input  logic [31:0]          req_label_pos,
   input  logic [31:0]          req_jump_patch_pos,
   input  logic [31:0]          req_jump_rel_base,
   input  logic                 q_full,
   output logic                 q_push,
   output xie_pkg::entry_type   q_entry
);

   logic [xie_pkg::AddrWidth-1:0] pos_ff;
   logic [xie_pkg::AddrWidth-1:0] pos_in;

   logic [xie_pkg::MaxBytes-1:0][7:0] enc_b;
   logic [xie_pkg::CountWidth-1:0]    enc_n;

   logic        accept;
   logic        has_sib;
   logic        disp_nz;
   logic        is_mem;
   logic        bad_req;
   logic        advance;
   logic [7:0]  sib;
   logic        m_rex_en;
   logic [7:0]  m_rex;
   logic [7:0]  m_op;
   logic [2:0]  m_r;
   logic        m_tail;
   logic [31:0] link_off;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign q_push = accept;

   // Memory operand fields shared by all memory requests.
   assign has_sib = (req_mem_scale != 3'd0);
   assign disp_nz = (req_mem_disp != 32'sd0);
   assign sib     = {2'(req_mem_scale - 3'd1), req_mem_index[2:0], req_mem_base[2:0]};
   assign is_mem  = (req_type == xie_pkg::REQ_CMP8MEM) || (req_type == xie_pkg::REQ_LOAD64) ||
                    (req_type == xie_pkg::REQ_STORE8) || (req_type == xie_pkg::REQ_JMPMEM);

   // Requests that cannot be encoded.
   assign bad_req = (req_type > xie_pkg::REQ_LINK) ||
                    (is_mem && (req_mem_scale > 3'd4)) ||
                    (((req_type == xie_pkg::REQ_LOAD64) || (req_type == xie_pkg::REQ_JMPMEM))
                     && disp_nz);

   assign link_off = req_label_pos - req_jump_rel_base;

   // Prefix, opcode and register field of each memory request.
   always_comb begin
      m_rex_en = 1'b1;
      m_rex    = {xie_pkg::REX_HIGH, 2'b00, has_sib & req_mem_index[3], req_mem_base[3]};
      m_op     = xie_pkg::OP_GRP1_IMM8;
      m_r      = 3'd7;
      m_tail   = 1'b1;
      case (req_type)
         xie_pkg::REQ_LOAD64: begin
            m_rex  = {xie_pkg::REX_HIGH, 1'b1, req_reg_a[3], has_sib & req_mem_index[3],
                      req_mem_base[3]};
            m_op   = xie_pkg::OP_MOV_LOAD;
            m_r    = req_reg_a[2:0];
            m_tail = 1'b0;
         end
         xie_pkg::REQ_STORE8: begin
            m_op = xie_pkg::OP_MOV_ST8;
            m_r  = 3'd0;
         end
         xie_pkg::REQ_JMPMEM: begin
            m_rex_en = (has_sib && (req_mem_index != 4'd0)) || (req_mem_base != 4'd0);
            m_op     = xie_pkg::OP_GRP5;
            m_r      = 3'd4;
            m_tail   = 1'b0;
         end
         default: begin
            m_rex_en = 1'b1;
         end
      endcase
   end

   // Byte encoder.
   always_comb begin
      enc_b = '0;
      enc_n = '0;
      unique case (req_type)
         xie_pkg::REQ_MOVIMM: begin
            enc_b[0]   = {xie_pkg::REX_HIGH, 1'b1, 2'b00, req_reg_a[3]};
            enc_b[1]   = xie_pkg::OP_MOV_IMM | {5'd0, req_reg_a[2:0]};
            enc_b[9:2] = req_imm;
            enc_n      = xie_pkg::CountWidth'(10);
         end
         xie_pkg::REQ_MOVREG, xie_pkg::REQ_CMP64: begin
            enc_b[0] = {xie_pkg::REX_HIGH, 1'b1, req_reg_b[3], 1'b0, req_reg_a[3]};
            enc_b[1] = (req_type == xie_pkg::REQ_MOVREG) ? xie_pkg::OP_MOV_RR : xie_pkg::OP_CMP_RR;
            enc_b[2] = {xie_pkg::MOD_REG, req_reg_b[2:0], req_reg_a[2:0]};
            enc_n    = xie_pkg::CountWidth'(3);
         end
         xie_pkg::REQ_CALL: begin
            enc_b[0] = xie_pkg::OP_GRP5;
            enc_b[1] = {xie_pkg::MOD_REG, 3'd2, req_reg_a[2:0]};
            enc_n    = xie_pkg::CountWidth'(2);
         end
         xie_pkg::REQ_CMP8MEM, xie_pkg::REQ_LOAD64, xie_pkg::REQ_STORE8,
         xie_pkg::REQ_JMPMEM: begin
            if (m_rex_en) begin
               enc_b[enc_n] = m_rex;
               enc_n = enc_n + 1'b1;
            end
            enc_b[enc_n] = m_op;
            enc_n = enc_n + 1'b1;
            enc_b[enc_n] = {(disp_nz ? xie_pkg::MOD_DISP32 : xie_pkg::MOD_NODISP), m_r,
                            (has_sib ? xie_pkg::RM_SIB : req_mem_base[2:0])};
            enc_n = enc_n + 1'b1;
            if (has_sib) begin
               enc_b[enc_n] = sib;
               enc_n = enc_n + 1'b1;
            end
            if (m_tail && disp_nz) begin
               enc_b[enc_n] = req_mem_disp[7:0];
               enc_n = enc_n + 1'b1;
               enc_b[enc_n] = req_mem_disp[15:8];
               enc_n = enc_n + 1'b1;
               enc_b[enc_n] = req_mem_disp[23:16];
               enc_n = enc_n + 1'b1;
               enc_b[enc_n] = req_mem_disp[31:24];
               enc_n = enc_n + 1'b1;
            end
            if (m_tail) begin
               enc_b[enc_n] = req_imm[7:0];
               enc_n = enc_n + 1'b1;
            end
         end
         xie_pkg::REQ_JMP: begin
            enc_b[0] = xie_pkg::OP_JMP_REL;
            enc_n    = xie_pkg::CountWidth'(5);
         end
         xie_pkg::REQ_JCC: begin
            enc_b[0] = xie_pkg::OP_ESCAPE;
            enc_b[1] = {xie_pkg::JCC_HIGH, req_cond};
            enc_n    = xie_pkg::CountWidth'(6);
         end
         xie_pkg::REQ_JMPREG: begin
            if (req_reg_a != 4'd0) begin
               enc_b[0] = {xie_pkg::REX_HIGH, 3'b000, req_reg_a[3]};
               enc_b[1] = xie_pkg::OP_GRP5;
               enc_b[2] = {xie_pkg::MOD_REG, 3'd4, req_reg_a[2:0]};
               enc_n    = xie_pkg::CountWidth'(3);
            end else begin
               enc_b[0] = xie_pkg::OP_GRP5;
               enc_b[1] = {xie_pkg::MOD_REG, 3'd4, req_reg_a[2:0]};
               enc_n    = xie_pkg::CountWidth'(2);
            end
         end
         xie_pkg::REQ_ADDIMM: begin
            enc_b[0]   = {xie_pkg::REX_HIGH, 1'b1, 2'b00, req_reg_a[3]};
            enc_b[1]   = xie_pkg::OP_GRP1_IMM32;
            enc_b[2]   = {xie_pkg::MOD_REG, 3'd0, req_reg_a[2:0]};
            enc_b[6:3] = req_imm[31:0];
            enc_n      = xie_pkg::CountWidth'(7);
         end
         xie_pkg::REQ_ADD64: begin
            enc_b[0] = {xie_pkg::REX_HIGH, 1'b1, req_reg_a[3], 1'b0, req_reg_b[3]};
            enc_b[1] = xie_pkg::OP_ADD_RR;
            enc_b[2] = {xie_pkg::MOD_REG, req_reg_a[2:0], req_reg_b[2:0]};
            enc_n    = xie_pkg::CountWidth'(3);
         end
         xie_pkg::REQ_RET: begin
            enc_b[0] = xie_pkg::OP_RET;
            enc_n    = xie_pkg::CountWidth'(1);
         end
         default: begin
            enc_b[0] = xie_pkg::OP_INT3;
            enc_n    = xie_pkg::CountWidth'(1);
         end
      endcase
   end

   // Classify the request and form the queue entry.
   always_comb begin
      q_entry          = '0;
      q_entry.addr     = pos_ff;
      q_entry.count    = xie_pkg::CountWidth'(1);
      advance          = 1'b0;
      if (bad_req) begin
         q_entry.no_write = 1'b1;
         q_entry.err      = 1'b1;
      end else if (req_type == xie_pkg::REQ_LABEL) begin
         q_entry.no_write = 1'b1;
      end else if (req_type == xie_pkg::REQ_LINK) begin
         q_entry.bytes[3:0] = link_off;
         q_entry.count      = xie_pkg::CountWidth'(4);
         q_entry.addr       = req_jump_patch_pos;
      end else begin
         q_entry.bytes = enc_b;
         q_entry.count = enc_n;
         advance       = 1'b1;
      end
   end

   // The write position moves by the length of each emitted instruction.
   assign pos_in = (accept && advance) ?
                   pos_ff + xie_pkg::AddrWidth'(enc_n) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/core/xie_queue.sv =====
module xie_queue #(
   parameter int unsigned Depth = xie_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  xie_pkg::entry_type  wr_entry,
   output logic                q_full,
   input  logic                rd_en,
   output logic                rd_valid,
   output xie_pkg::entry_type  rd_entry
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   xie_pkg::entry_type     slot_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff;
   logic [PtrWidth-1:0]    wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff;
   logic [PtrWidth-1:0]    rd_ptr_in;
   logic [CntWidth-1:0]    cnt_ff;
   logic [CntWidth-1:0]    cnt_in;
   logic                   do_wr;
   logic                   do_rd;

   assign q_full   = (cnt_ff == CntWidth'(Depth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_entry = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_wr, do_rd})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ===== rtl/core/xie_back.sv =====
module xie_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  xie_pkg::entry_type  head,
   output logic                head_pop,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          rsp_byte_value,
   output logic [31:0]         rsp_byte_addr,
   output logic                rsp_write_valid,
   output logic                rsp_error,
   output logic                rsp_last
);

   logic [xie_pkg::CountWidth-1:0] idx_ff;
   logic [xie_pkg::CountWidth-1:0] idx_in;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [7:0]                     value_ff;
   logic [31:0]                    addr_ff;
   logic                           wv_ff;
   logic                           err_ff;
   logic                           last_ff;
   logic                           step;
   logic                           at_last;

   // A new result enters when the output register is free or being drained.
   assign step     = head_valid && (!out_valid_ff || pop);
   assign at_last  = (idx_ff == head.count - 1'b1);
   assign head_pop = step && at_last;

   always_comb begin
      idx_in = idx_ff;
      if (step) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= head.no_write ? 8'd0 : head.bytes[idx_ff];
         addr_ff  <= head.addr + 32'(idx_ff);
         wv_ff    <= !head.no_write;
         err_ff   <= head.err;
         last_ff  <= at_last;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_byte_value  = value_ff;
   assign rsp_byte_addr   = addr_ff;
   assign rsp_write_valid = wv_ff;
   assign rsp_error       = err_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/core/x86_64_instruction_encoder_unit.sv =====
// Channel     Ports                         Transaction
// request     push, full, req_*             one instruction request
// result      empty, pop, rsp_*             one byte write, label or error
//
// The front part encodes a request in the cycle it is taken and keeps the write position.
// The back part sends one result per cycle through a one-entry output register while
// pop keeps taking them; a request gives 1 to 10 results.
// Requests keep entering while earlier ones drain, until the queue of QueueDepth fills.
// Synchronous reset clears the write position, the queue and the output register.
module x86_64_instruction_encoder_unit #(
   parameter int unsigned QueueDepth = xie_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [4:0]          req_type,
   input  logic [3:0]          req_reg_a,
   input  logic [3:0]          req_reg_b,
   input  logic [3:0]          req_mem_base,
   input  logic [3:0]          req_mem_index,
   input  logic [2:0]          req_mem_scale,
   input  logic signed [31:0]  req_mem_disp,
   input  logic [63:0]         req_imm,
   input  logic [3:0]          req_cond,
   input  logic [31:0]         req_label_pos,
   input  logic [31:0]         req_jump_patch_pos,
   input  logic [31:0]         req_jump_rel_base,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          rsp_byte_value,
   output logic [31:0]         rsp_byte_addr,
   output logic                rsp_write_valid,
   output logic                rsp_error,
   output logic                rsp_last
);

   logic               q_full;
   logic               q_push;
   xie_pkg::entry_type q_wr_entry;
   logic               q_rd_valid;
   xie_pkg::entry_type q_rd_entry;
   logic               q_pop;

   // Encoder and write position counter.
   xie_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_reg_a          (req_reg_a),
      .req_reg_b          (req_reg_b),
      .req_mem_base       (req_mem_base),
      .req_mem_index      (req_mem_index),
      .req_mem_scale      (req_mem_scale),
      .req_mem_disp       (req_mem_disp),
      .req_imm            (req_imm),
      .req_cond           (req_cond),
      .req_label_pos      (req_label_pos),
      .req_jump_patch_pos (req_jump_patch_pos),
      .req_jump_rel_base  (req_jump_rel_base),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (q_wr_entry)
   );

   // Queue of encoded requests.
   xie_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (q_wr_entry),
      .q_full   (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_rd_valid),
      .rd_entry (q_rd_entry)
   );

   // Byte serializer and output register.
   xie_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_rd_valid),
      .head            (q_rd_entry),
      .head_pop        (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_byte_addr   (rsp_byte_addr),
      .rsp_write_valid (rsp_write_valid),
      .rsp_error       (rsp_error),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/core/xie_checker.sv =====
`include "assert_macros.svh"

module xie_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [7:0]  rsp_byte_value,
   input logic [31:0] rsp_byte_addr,
   input logic        rsp_write_valid,
   input logic        rsp_error,
   input logic        rsp_last
);

   logic [7:0]  prev_value_ff;
   logic [31:0] prev_addr_ff;
   logic        waiting;
   logic        mid_take;
   logic        nowrite_shown;
   logic        nowrite_ok;
   logic        error_shown;
   logic        same_payload;
   logic        addr_next;

   // The result payload as it stood in the previous cycle.
   always_ff @(posedge clock) begin
      prev_value_ff <= rsp_byte_value;
      prev_addr_ff  <= rsp_byte_addr;
   end

   assign waiting       = !empty && !pop;
   assign mid_take      = !empty && pop && !rsp_last;
   assign nowrite_shown = !empty && !rsp_write_valid;
   assign nowrite_ok    = rsp_last && (rsp_byte_value == 8'd0);
   assign error_shown   = !empty && rsp_error;
   assign same_payload  = (rsp_byte_value == prev_value_ff) && (rsp_byte_addr == prev_addr_ff);
   assign addr_next     = (rsp_byte_addr == prev_addr_ff + 32'd1);

   // Reset leaves no result waiting.
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> empty, "result waiting after reset")

   // A result that is not a byte write is a single zero result.
   `ASSERT_CLK(a_nowrite_single, clock, reset, nowrite_shown |-> nowrite_ok, "non-write not single")

   // An error never writes a byte.
   `ASSERT_CLK(a_error_nowrite, clock, reset, error_shown |-> !rsp_write_valid, "error writes")

   // Bytes of one transaction go to consecutive addresses.
   `ASSERT_CLK(a_addr_seq, clock, reset, mid_take ##1 !empty |-> addr_next, "addr not consecutive")

   // A waiting result holds until it is taken.
   `ASSERT_CLK(a_hold, clock, reset, waiting |=> (!empty && same_payload), "waiting result changed")

endmodule

bind x86_64_instruction_encoder_unit xie_checker u_xie_checker (
   .clock           (clock),
   .reset           (reset),
   .empty           (empty),
   .pop             (pop),
   .rsp_byte_value  (rsp_byte_value),
   .rsp_byte_addr   (rsp_byte_addr),
   .rsp_write_valid (rsp_write_valid),
   .rsp_error       (rsp_error),
   .rsp_last        (rsp_last)
);

// ===== tb/sv/x86_64_instruction_encoder_unit_tb.sv =====
`timescale 1ns / 100ps

module x86_64_instruction_encoder_unit_tb;

   // Request codes that the encoder must reject.
   localparam logic [4:0] REQ_UNKNOWN_FIRST = 5'd17;
   localparam logic [4:0] REQ_UNKNOWN_LAST  = 5'd31;

   // Opcode bytes and ModRM pieces as the encoder is expected to produce them.
   localparam logic [7:0] OPC_MOV_R64_IMM64 = 8'hB8;
   localparam logic [7:0] OPC_MOV_STORE     = 8'h89;
   localparam logic [7:0] OPC_GRP1_IMM8     = 8'h80;
   localparam logic [7:0] OPC_CMP_STORE     = 8'h39;
   localparam logic [7:0] OPC_MOV_LOAD      = 8'h8B;
   localparam logic [7:0] OPC_MOV_MEM_IMM8  = 8'hC6;
   localparam logic [7:0] OPC_JMP_REL32     = 8'hE9;
   localparam logic [7:0] OPC_TWO_BYTE      = 8'h0F;
   localparam logic [7:0] OPC_JCC_REL32     = 8'h80;
   localparam logic [7:0] OPC_GRP1_IMM32    = 8'h81;
   localparam logic [7:0] OPC_ADD_LOAD      = 8'h03;
   localparam logic [7:0] OPC_RET_NEAR      = 8'hC3;
   localparam logic [7:0] OPC_BREAKPOINT    = 8'hCC;
   localparam logic [7:0] OPC_GRP5          = 8'hFF;
   localparam logic [3:0] REX_FIXED         = 4'h4;
   localparam logic [3:0] EXT_ADD           = 4'd0;
   localparam logic [3:0] EXT_CALL          = 4'd2;
   localparam logic [3:0] EXT_JMP           = 4'd4;
   localparam logic [3:0] EXT_CMP           = 4'd7;
   localparam logic [1:0] MODE_REGISTER     = 2'b11;
   localparam logic [1:0] MODE_DISP32       = 2'b10;
   localparam logic [1:0] MODE_INDIRECT     = 2'b00;
   localparam logic [3:0] RM_SIB_ESCAPE     = 4'd4;

   localparam int LongHoldCycles = 80;
   localparam int DrainLimit     = 20000;
   localparam int SettleCycles   = 30;

   // One instruction request as it is driven onto the request ports.
   typedef struct packed {
      logic [4:0]  kind;
      logic [3:0]  reg_a;
      logic [3:0]  reg_b;
      logic [3:0]  base;
      logic [3:0]  index;
      logic [2:0]  scale;
      logic [31:0] disp;
      logic [63:0] imm;
      logic [3:0]  cond;
      logic [31:0] label_pos;
      logic [31:0] patch_pos;
      logic [31:0] rel_base;
   } encode_req_type;

   // One byte write, label or error as it is expected on the result ports.
   typedef struct packed {
      logic [7:0]  value;
      logic [31:0] addr;
      logic        write_valid;
      logic        error;
      logic        last;
   } code_write_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [4:0]  req_type;
   logic [3:0]  req_reg_a;
   logic [3:0]  req_reg_b;
   logic [3:0]  req_mem_base;
   logic [3:0]  req_mem_index;
   logic [2:0]  req_mem_scale;
   logic signed [31:0] req_mem_disp;
   logic [63:0] req_imm;
   logic [3:0]  req_cond;
   logic [31:0] req_label_pos;
   logic [31:0] req_jump_patch_pos;
   logic [31:0] req_jump_rel_base;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_byte_value;
   logic [31:0] rsp_byte_addr;
   logic        rsp_write_valid;
   logic        rsp_error;
   logic        rsp_last;

   // Predictor state and the results still owed by the encoder.
   logic [31:0] code_position;
   logic [7:0]  code_bytes[$];
   code_write_type predicted_writes[$];

   int failures = 0;
   int stall_left = 0;
   bit sender_idle_enable = 1'b1;
   bit receiver_idle_enable = 1'b1;
   bit receiver_hold_request = 1'b0;

   x86_64_instruction_encoder_unit dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_reg_a          (req_reg_a),
      .req_reg_b          (req_reg_b),
      .req_mem_base       (req_mem_base),
      .req_mem_index      (req_mem_index),
      .req_mem_scale      (req_mem_scale),
      .req_mem_disp       (req_mem_disp),
      .req_imm            (req_imm),
      .req_cond           (req_cond),
      .req_label_pos      (req_label_pos),
      .req_jump_patch_pos (req_jump_patch_pos),
      .req_jump_rel_base  (req_jump_rel_base),
      .empty              (empty),
      .pop                (pop),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_byte_addr      (rsp_byte_addr),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_error          (rsp_error),
      .rsp_last           (rsp_last)
   );

   always #6 clock = ~clock;

   // Byte emitters used by the encoding predictor.
   function automatic void put_dword(logic [31:0] v);
      for (int i = 0; i < 4; i++) code_bytes.push_back(v[8*i +: 8]);
   endfunction

   // REX goes out when forced, when W is set, or when any register number is nonzero.
   function automatic void put_rex(logic [3:0] r, logic [3:0] x, logic [3:0] rm, logic w,
                                   logic forced);
      if (forced || r != 0 || x != 0 || rm != 0 || w)
         code_bytes.push_back({REX_FIXED, w, r[3], x[3], rm[3]});
   endfunction

   function automatic void put_modrm(logic [1:0] mode, logic [3:0] r, logic [3:0] rm);
      code_bytes.push_back({mode, r[2:0], rm[2:0]});
   endfunction

   // A scaled operand puts the SIB escape in r/m and follows with the SIB byte.
   function automatic void put_mem_operand(logic [3:0] r, logic [3:0] base, logic [3:0] index,
                                           logic [2:0] scale, logic [31:0] disp);
      logic [1:0] mode;
      logic [2:0] scale_code;
      mode = (disp != 0) ? MODE_DISP32 : MODE_INDIRECT;
      scale_code = scale - 3'd1;
      if (scale != 0) begin
         put_modrm(mode, r, RM_SIB_ESCAPE);
         code_bytes.push_back({scale_code[1:0], index[2:0], base[2:0]});
      end else begin
         put_modrm(mode, r, base);
      end
   endfunction

   function automatic void queue_write(logic [7:0] value, logic [31:0] addr, logic wv,
                                       logic err, logic last);
      code_write_type w;
      w.value = value;
      w.addr = addr;
      w.write_valid = wv;
      w.error = err;
      w.last = last;
      predicted_writes.push_back(w);
   endfunction

   // Works out the results of one accepted request and advances the write position.
   function automatic void predict_encoding(encode_req_type r);
      logic [3:0]  sib_index;
      logic [31:0] offset;
      logic        mem_access;
      logic        no_disp_allowed;
      int          n;
      code_bytes.delete();
      sib_index = (r.scale != 0) ? r.index : 4'd0;
      mem_access = (r.kind == xie_pkg::REQ_CMP8MEM || r.kind == xie_pkg::REQ_LOAD64 ||
                    r.kind == xie_pkg::REQ_STORE8 || r.kind == xie_pkg::REQ_JMPMEM);
      no_disp_allowed = (r.kind == xie_pkg::REQ_LOAD64 || r.kind == xie_pkg::REQ_JMPMEM);
      if (r.kind > xie_pkg::REQ_LINK || (mem_access && r.scale > 3'd4) ||
          (no_disp_allowed && r.disp != 0)) begin
         queue_write(8'h00, code_position, 1'b0, 1'b1, 1'b1);
         return;
      end
      if (r.kind == xie_pkg::REQ_LABEL) begin
         queue_write(8'h00, code_position, 1'b0, 1'b0, 1'b1);
         return;
      end
      // A link patches the rel32 field in place and leaves the position alone.
      if (r.kind == xie_pkg::REQ_LINK) begin
         offset = r.label_pos - r.rel_base;
         for (int i = 0; i < 4; i++)
            queue_write(offset[8*i +: 8], r.patch_pos + i, 1'b1, 1'b0, i == 3);
         return;
      end
      case (r.kind)
         xie_pkg::REQ_MOVIMM: begin
            put_rex(4'd0, 4'd0, r.reg_a, 1'b1, 1'b0);
            code_bytes.push_back(OPC_MOV_R64_IMM64 + r.reg_a[2:0]);
            put_dword(r.imm[31:0]);
            put_dword(r.imm[63:32]);
         end
         xie_pkg::REQ_MOVREG: begin
            put_rex(r.reg_b, 4'd0, r.reg_a, 1'b1, 1'b0);
            code_bytes.push_back(OPC_MOV_STORE);
            put_modrm(MODE_REGISTER, r.reg_b, r.reg_a);
         end
         xie_pkg::REQ_CALL: begin
            code_bytes.push_back(OPC_GRP5);
            put_modrm(MODE_REGISTER, EXT_CALL, r.reg_a);
         end
         xie_pkg::REQ_CMP8MEM: begin
            put_rex(EXT_CMP, sib_index, r.base, 1'b0, 1'b0);
            code_bytes.push_back(OPC_GRP1_IMM8);
            put_mem_operand(EXT_CMP, r.base, r.index, r.scale, r.disp);
            if (r.disp != 0) put_dword(r.disp);
            code_bytes.push_back(r.imm[7:0]);
         end
         xie_pkg::REQ_CMP64: begin
            put_rex(r.reg_b, 4'd0, r.reg_a, 1'b1, 1'b0);
            code_bytes.push_back(OPC_CMP_STORE);
            put_modrm(MODE_REGISTER, r.reg_b, r.reg_a);
         end
         xie_pkg::REQ_LOAD64: begin
            put_rex(r.reg_a, sib_index, r.base, 1'b1, 1'b0);
            code_bytes.push_back(OPC_MOV_LOAD);
            put_mem_operand(r.reg_a, r.base, r.index, r.scale, 32'd0);
         end
         xie_pkg::REQ_STORE8: begin
            put_rex(4'd0, sib_index, r.base, 1'b0, 1'b1);
            code_bytes.push_back(OPC_MOV_MEM_IMM8);
            put_mem_operand(4'd0, r.base, r.index, r.scale, r.disp);
            if (r.disp != 0) put_dword(r.disp);
            code_bytes.push_back(r.imm[7:0]);
         end
         xie_pkg::REQ_JMP: begin
            code_bytes.push_back(OPC_JMP_REL32);
            put_dword(32'd0);
         end
         xie_pkg::REQ_JCC: begin
            code_bytes.push_back(OPC_TWO_BYTE);
            code_bytes.push_back(OPC_JCC_REL32 + r.cond);
            put_dword(32'd0);
         end
         xie_pkg::REQ_JMPREG: begin
            put_rex(4'd0, 4'd0, r.reg_a, 1'b0, 1'b0);
            code_bytes.push_back(OPC_GRP5);
            put_modrm(MODE_REGISTER, EXT_JMP, r.reg_a);
         end
         xie_pkg::REQ_JMPMEM: begin
            put_rex(4'd0, sib_index, r.base, 1'b0, 1'b0);
            code_bytes.push_back(OPC_GRP5);
            put_mem_operand(EXT_JMP, r.base, r.index, r.scale, 32'd0);
         end
         xie_pkg::REQ_ADDIMM: begin
            put_rex(4'd0, 4'd0, r.reg_a, 1'b1, 1'b0);
            code_bytes.push_back(OPC_GRP1_IMM32);
            put_modrm(MODE_REGISTER, EXT_ADD, r.reg_a);
            put_dword(r.imm[31:0]);
         end
         xie_pkg::REQ_ADD64: begin
            put_rex(r.reg_a, 4'd0, r.reg_b, 1'b1, 1'b0);
            code_bytes.push_back(OPC_ADD_LOAD);
            put_modrm(MODE_REGISTER, r.reg_a, r.reg_b);
         end
         xie_pkg::REQ_RET: code_bytes.push_back(OPC_RET_NEAR);
         default: code_bytes.push_back(OPC_BREAKPOINT);
      endcase
      n = code_bytes.size();
      for (int i = 0; i < n; i++)
         queue_write(code_bytes[i], code_position + i, 1'b1, 1'b0, i == n - 1);
      code_position = code_position + n;
   endfunction

   function automatic encode_req_type blank_request(logic [4:0] kind);
      encode_req_type r;
      r = '0;
      r.kind = kind;
      return r;
   endfunction

   // Mostly legal requests; a few unknown codes, bad scales and stray displacements.
   function automatic encode_req_type random_request();
      encode_req_type r;
      if ($urandom_range(0, 15) == 0)
         r.kind = 5'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
      else
         r.kind = 5'($urandom_range(xie_pkg::REQ_MOVIMM, xie_pkg::REQ_LINK));
      r.reg_a = 4'($urandom);
      r.reg_b = 4'($urandom);
      r.base = 4'($urandom);
      r.index = 4'($urandom);
      if ($urandom_range(0, 9) == 0)
         r.scale = 3'($urandom_range(5, 7));
      else
         r.scale = 3'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
         0, 1: r.disp = 32'd0;
         2: r.disp = $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: r.disp = 32'h8000_0000;
               1: r.disp = 32'h7FFF_FFFF;
               2: r.disp = 32'hFFFF_FFFF;
               default: r.disp = 32'd1;
            endcase
         end
      endcase
      if ((r.kind == xie_pkg::REQ_LOAD64 || r.kind == xie_pkg::REQ_JMPMEM) &&
          $urandom_range(0, 4) != 0)
         r.disp = 32'd0;
      r.imm = {$urandom, $urandom};
      r.cond = 4'($urandom);
      r.label_pos = $urandom;
      r.patch_pos = $urandom;
      r.rel_base = $urandom;
      return r;
   endfunction

   // Offers one request until the encoder takes it, then predicts its results.
   task automatic send_request(input encode_req_type r);
      if (sender_idle_enable && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      push               <= 1'b1;
      req_type           <= r.kind;
      req_reg_a          <= r.reg_a;
      req_reg_b          <= r.reg_b;
      req_mem_base       <= r.base;
      req_mem_index      <= r.index;
      req_mem_scale      <= r.scale;
      req_mem_disp       <= r.disp;
      req_imm            <= r.imm;
      req_cond           <= r.cond;
      req_label_pos      <= r.label_pos;
      req_jump_patch_pos <= r.patch_pos;
      req_jump_rel_base  <= r.rel_base;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_encoding(r);
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endfunction

   // Result side: checks each accepted transaction and stalls in random bursts.
   always @(posedge clock) begin
      code_write_type want;
      if (reset) begin
         pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (pop && !empty) begin
            if (predicted_writes.size() == 0) begin
               $error("unexpected result: byte %0h at %0h", rsp_byte_value, rsp_byte_addr);
               failures++;
            end else begin
               want = predicted_writes.pop_front();
               check_field("byte_value", 64'(want.value), 64'(rsp_byte_value));
               check_field("byte_addr", 64'(want.addr), 64'(rsp_byte_addr));
               check_field("write_valid", 64'(want.write_valid), 64'(rsp_write_valid));
               check_field("error", 64'(want.error), 64'(rsp_error));
               check_field("last", 64'(want.last), 64'(rsp_last));
            end
         end
         if (receiver_hold_request) begin
            receiver_hold_request = 1'b0;
            stall_left = LongHoldCycles;
         end else if (stall_left == 0 && receiver_idle_enable && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7);
         end
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Each request kind at least once, several with register numbers, scales and immediates at their extremes.
   task automatic test_directed_encodings();
      encode_req_type r;
      r = blank_request(xie_pkg::REQ_MOVIMM);
      r.reg_a = 4'd15;
      r.imm = '1;
      send_request(r);
      send_request(blank_request(xie_pkg::REQ_MOVREG));
      r = blank_request(xie_pkg::REQ_MOVREG);
      r.reg_a = 4'd15;
      r.reg_b = 4'd15;
      send_request(r);
      r = blank_request(xie_pkg::REQ_CALL);
      r.reg_a = 4'd15;
      send_request(r);
      r = blank_request(xie_pkg::REQ_CMP8MEM);
      r.base = 4'd15;
      r.index = 4'd15;
      r.scale = 3'd4;
      r.disp = 32'h8000_0000;
      r.imm = 64'hFF;
      send_request(r);
      send_request(blank_request(xie_pkg::REQ_CMP8MEM));
      r = blank_request(xie_pkg::REQ_CMP64);
      r.reg_a = 4'd9;
      r.reg_b = 4'd3;
      send_request(r);
      r = blank_request(xie_pkg::REQ_LOAD64);
      r.reg_a = 4'd8;
      r.base = 4'd12;
      r.index = 4'd4;
      r.scale = 3'd1;
      send_request(r);
      // A store always carries REX, even with every register number zero.
      send_request(blank_request(xie_pkg::REQ_STORE8));
      r = blank_request(xie_pkg::REQ_STORE8);
      r.base = 4'd5;
      r.index = 4'd13;
      r.scale = 3'd3;
      r.disp = 32'h7FFF_FFFF;
      r.imm = 64'h5A;
      send_request(r);
      send_request(blank_request(xie_pkg::REQ_JMP));
      r = blank_request(xie_pkg::REQ_JCC);
      r.cond = 4'd15;
      send_request(r);
      send_request(blank_request(xie_pkg::REQ_JMPREG));
      r = blank_request(xie_pkg::REQ_JMPREG);
      r.reg_a = 4'd12;
      send_request(r);
      r = blank_request(xie_pkg::REQ_JMPMEM);
      r.base = 4'd3;
      r.index = 4'd9;
      r.scale = 3'd2;
      send_request(r);
      r = blank_request(xie_pkg::REQ_ADDIMM);
      r.reg_a = 4'd7;
      r.imm = 64'hFFFF_FFFF_8000_0001;
      send_request(r);
      r = blank_request(xie_pkg::REQ_ADD64);
      r.reg_a = 4'd15;
      send_request(r);
      send_request(blank_request(xie_pkg::REQ_RET));
      send_request(blank_request(xie_pkg::REQ_INT3));
      send_request(blank_request(xie_pkg::REQ_LABEL));
      // Patch addresses and the offset both wrap around 2^32.
      r = blank_request(xie_pkg::REQ_LINK);
      r.patch_pos = 32'hFFFF_FFFE;
      r.rel_base = 32'hFFFF_FFFF;
      send_request(r);
   endtask

   // Requests that give a single error transaction and leave the position alone.
   task automatic test_error_requests();
      encode_req_type r;
      r = blank_request(xie_pkg::REQ_LOAD64);
      r.disp = 32'd1;
      send_request(r);
      r = blank_request(xie_pkg::REQ_JMPMEM);
      r.disp = 32'hFFFF_FFFF;
      send_request(r);
      r = blank_request(xie_pkg::REQ_CMP8MEM);
      r.scale = 3'd7;
      send_request(r);
      r = blank_request(xie_pkg::REQ_STORE8);
      r.scale = 3'd5;
      send_request(r);
      send_request(blank_request(REQ_UNKNOWN_LAST));
      send_request(blank_request(REQ_UNKNOWN_FIRST));
   endtask

   task automatic send_random_body();
      repeat ($urandom_range(0, 4)) send_request(random_request());
   endtask

   // Jumps that are later resolved against a label, as a code generator would issue them.
   task automatic test_branch_linking();
      encode_req_type jump_req;
      encode_req_type link_req;
      logic [31:0] target;
      logic [31:0] patch_at;
      bit          backward;
      repeat (25) begin
         backward = 1'($urandom_range(0, 1));
         jump_req = random_request();
         jump_req.kind = $urandom_range(0, 1) ? xie_pkg::REQ_JCC : xie_pkg::REQ_JMP;
         if (backward) begin
            target = code_position;
            send_request(blank_request(xie_pkg::REQ_LABEL));
            send_random_body();
         end
         patch_at = code_position + ((jump_req.kind == xie_pkg::REQ_JCC) ? 2 : 1);
         send_request(jump_req);
         if (!backward) begin
            send_random_body();
            target = code_position;
            send_request(blank_request(xie_pkg::REQ_LABEL));
         end
         link_req = blank_request(xie_pkg::REQ_LINK);
         link_req.label_pos = target;
         link_req.patch_pos = patch_at;
         link_req.rel_base = patch_at + 4;
         send_request(link_req);
      end
   endtask

   task automatic test_random_requests();
      repeat (140) send_request(random_request());
   endtask

   // The result side holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      sender_idle_enable = 1'b0;
      receiver_hold_request = 1'b1;
      repeat (12) send_request(random_request());
   endtask

   task automatic test_streaming_no_idle();
      sender_idle_enable = 1'b0;
      receiver_idle_enable = 1'b0;
      repeat (40) send_request(random_request());
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      push = 1'b0;
      req_type = '0;
      req_reg_a = '0;
      req_reg_b = '0;
      req_mem_base = '0;
      req_mem_index = '0;
      req_mem_scale = '0;
      req_mem_disp = '0;
      req_imm = '0;
      req_cond = '0;
      req_label_pos = '0;
      req_jump_patch_pos = '0;
      req_jump_rel_base = '0;
      code_position = '0;
      waited = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_encodings();
      test_error_requests();
      test_branch_linking();
      test_random_requests();
      test_output_backpressure();
      test_streaming_no_idle();
      push <= 1'b0;

      // Let the encoder drain, then watch a little longer for stray transactions.
      while (predicted_writes.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (predicted_writes.size() != 0) begin
         $error("%0d expected results never arrived", predicted_writes.size());
         failures++;
      end
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
